@@ rtl/core/lohs_pkg.sv @@
// Shared types and constants for the LRU ordered history set.
`timescale 1ns / 1ps

package lohs_pkg;

    // Fixed field widths of the request and result ports
    localparam int KEY_W       = 64;
    localparam int FP_PORT_W   = 64;
    localparam int SLOT_PORT_W = 4;
    localparam int FILL_PORT_W = 5;

    // Request commands
    typedef enum logic [1:0] {
        CMD_LOOKUP_OFFSET = 2'd0,
        CMD_LOOKUP_ADDR   = 2'd1,
        CMD_INSERT        = 2'd2,
        CMD_TOUCH         = 2'd3
    } lohs_cmd_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE    = 1'b0,
        ST_RESOLVE = 1'b1
    } lohs_state_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic shift;    // load the entry handed over by the left neighbor
        logic cmp_en;   // capture the key compare for a new request
        logic by_addr;  // compare the address key instead of the offset key
    } lohs_cell_ctl_t;

endpackage

@@ rtl/core/lru_ordered_history_set.sv @@
// Top level of the LRU ordered history set: chain of entry cells and sequencer.
`timescale 1ns / 1ps

// Fully associative history table with ENTRIES slots kept in recency order.
// The entries live in a row of cells, most recent at cell 0; promotion and
// insert shift the row right by one cell up to the affected position, so the
// cell order is the recency order. For each request, at the accept edge every
// cell registers the compare of its key with the request; in the resolve state
// the sequencer then resolves the per-cell match bits (most recent match for
// lookups, lowest slot number for touch), writes the result register and
// shifts the chain. The input stalls in the resolve state, held while the
// result register holds an untaken result. Lookups never reorder. Insert takes
// the next free slot, or the least recent one when full. No clearing pass is
// needed after reset: only positions below the fill count are ever searched.
module lru_ordered_history_set #(
    parameter int ENTRIES        = 16,
    parameter int FOOTPRINT_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  lohs_pkg::lohs_cmd_t                  cmd,
    input  logic [lohs_pkg::KEY_W-1:0]           offset_key,
    input  logic [lohs_pkg::KEY_W-1:0]           address_key,
    input  logic [lohs_pkg::FP_PORT_W-1:0]       entry_footprint,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic [lohs_pkg::SLOT_PORT_W-1:0]     slot,
    output logic [lohs_pkg::FP_PORT_W-1:0]       found_footprint,
    output logic [lohs_pkg::FILL_PORT_W-1:0]     fill_count
);
    import lohs_pkg::*;

    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W = $clog2(ENTRIES + 1);

    lohs_cell_ctl_t [ENTRIES-1:0]            cell_ctl;
    logic [ENTRIES-1:0]                      cell_match;
    logic [ENTRIES-1:0][KEY_W-1:0]           cell_okey;
    logic [ENTRIES-1:0][KEY_W-1:0]           cell_akey;
    logic [ENTRIES-1:0][FOOTPRINT_BITS-1:0]  cell_fp;
    logic [ENTRIES-1:0][SLOT_W-1:0]          cell_slot;

    logic [ENTRIES-1:0][KEY_W-1:0]           chain_okey;
    logic [ENTRIES-1:0][KEY_W-1:0]           chain_akey;
    logic [ENTRIES-1:0][FOOTPRINT_BITS-1:0]  chain_fp;
    logic [ENTRIES-1:0][SLOT_W-1:0]          chain_slot;

    logic [KEY_W-1:0]                        head_okey;
    logic [KEY_W-1:0]                        head_akey;
    logic [FOOTPRINT_BITS-1:0]               head_fp;
    logic [SLOT_W-1:0]                       head_slot;

    lohs_ctrl #(
        .ENTRIES        (ENTRIES),
        .FOOTPRINT_BITS (FOOTPRINT_BITS),
        .SLOT_W         (SLOT_W),
        .COUNT_W        (COUNT_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .offset_key       (offset_key),
        .address_key      (address_key),
        .entry_footprint  (entry_footprint),
        .cell_match       (cell_match),
        .cell_offset_key  (cell_okey),
        .cell_address_key (cell_akey),
        .cell_footprint   (cell_fp),
        .cell_slot        (cell_slot),
        .cell_ctl         (cell_ctl),
        .head_offset_key  (head_okey),
        .head_address_key (head_akey),
        .head_footprint   (head_fp),
        .head_slot        (head_slot),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .slot             (slot),
        .found_footprint  (found_footprint),
        .fill_count       (fill_count)
    );

    // Build the row: each cell takes its left neighbor, cell 0 takes the head
    for (genvar c = 0; c < ENTRIES; c++)
    begin : g_cell
        if (c == 0)
        begin : g_head
            assign chain_okey[c] = head_okey;
            assign chain_akey[c] = head_akey;
            assign chain_fp[c]   = head_fp;
            assign chain_slot[c] = head_slot;
        end
        else
        begin : g_link
            assign chain_okey[c] = cell_okey[c-1];
            assign chain_akey[c] = cell_akey[c-1];
            assign chain_fp[c]   = cell_fp[c-1];
            assign chain_slot[c] = cell_slot[c-1];
        end

        lohs_cell #(
            .FOOTPRINT_BITS (FOOTPRINT_BITS),
            .SLOT_W         (SLOT_W)
        ) u_cell (
            .clk              (clk),
            .rst_n            (rst_n),
            .ctl              (cell_ctl[c]),
            .offset_key       (offset_key),
            .address_key      (address_key),
            .prev_offset_key  (chain_okey[c]),
            .prev_address_key (chain_akey[c]),
            .prev_footprint   (chain_fp[c]),
            .prev_slot        (chain_slot[c]),
            .cell_offset_key  (cell_okey[c]),
            .cell_address_key (cell_akey[c]),
            .cell_footprint   (cell_fp[c]),
            .cell_slot        (cell_slot[c]),
            .match            (cell_match[c])
        );
    end

endmodule

@@ rtl/core/lohs_cell.sv @@
// One recency position of the chain: entry storage, key compare and shift.
`timescale 1ns / 1ps

module lohs_cell #(
    parameter int FOOTPRINT_BITS = 64,
    parameter int SLOT_W         = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lohs_pkg::lohs_cell_ctl_t      ctl,
    input  logic [lohs_pkg::KEY_W-1:0]    offset_key,
    input  logic [lohs_pkg::KEY_W-1:0]    address_key,
    input  logic [lohs_pkg::KEY_W-1:0]    prev_offset_key,
    input  logic [lohs_pkg::KEY_W-1:0]    prev_address_key,
    input  logic [FOOTPRINT_BITS-1:0]     prev_footprint,
    input  logic [SLOT_W-1:0]             prev_slot,
    output logic [lohs_pkg::KEY_W-1:0]    cell_offset_key,
    output logic [lohs_pkg::KEY_W-1:0]    cell_address_key,
    output logic [FOOTPRINT_BITS-1:0]     cell_footprint,
    output logic [SLOT_W-1:0]             cell_slot,
    output logic                          match
);
    import lohs_pkg::*;

    logic [KEY_W-1:0]          okey_reg;
    logic [KEY_W-1:0]          akey_reg;
    logic [FOOTPRINT_BITS-1:0] fp_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic                      match_reg;
    logic                      match_next;

    // Compare the selected request key against this entry
    always_comb
    begin
        if (ctl.by_addr)
        begin
            match_next = (akey_reg == address_key);
        end
        else
        begin
            match_next = (okey_reg == offset_key);
        end
    end

    // Hold the compare result until the request resolves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            match_reg <= match_next;
        end
    end

    // Take the neighbor's entry when the chain advances
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            okey_reg <= prev_offset_key;
            akey_reg <= prev_address_key;
            fp_reg   <= prev_footprint;
            slot_reg <= prev_slot;
        end
    end

    assign cell_offset_key  = okey_reg;
    assign cell_address_key = akey_reg;
    assign cell_footprint   = fp_reg;
    assign cell_slot        = slot_reg;
    assign match            = match_reg;

endmodule

@@ rtl/core/lohs_ctrl.sv @@
// Sequencer: request capture, match resolution, chain shift control and result register.
`timescale 1ns / 1ps

module lohs_ctrl #(
    parameter int ENTRIES        = 16,
    parameter int FOOTPRINT_BITS = 64,
    parameter int SLOT_W         = 4,
    parameter int COUNT_W        = 5
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  lohs_pkg::lohs_cmd_t                          cmd,
    input  logic [lohs_pkg::KEY_W-1:0]                   offset_key,
    input  logic [lohs_pkg::KEY_W-1:0]                   address_key,
    input  logic [lohs_pkg::FP_PORT_W-1:0]               entry_footprint,
    input  logic [ENTRIES-1:0]                           cell_match,
    input  logic [ENTRIES-1:0][lohs_pkg::KEY_W-1:0]      cell_offset_key,
    input  logic [ENTRIES-1:0][lohs_pkg::KEY_W-1:0]      cell_address_key,
    input  logic [ENTRIES-1:0][FOOTPRINT_BITS-1:0]       cell_footprint,
    input  logic [ENTRIES-1:0][SLOT_W-1:0]               cell_slot,
    output lohs_pkg::lohs_cell_ctl_t [ENTRIES-1:0]       cell_ctl,
    output logic [lohs_pkg::KEY_W-1:0]                   head_offset_key,
    output logic [lohs_pkg::KEY_W-1:0]                   head_address_key,
    output logic [FOOTPRINT_BITS-1:0]                    head_footprint,
    output logic [SLOT_W-1:0]                            head_slot,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic                                         hit,
    output logic [lohs_pkg::SLOT_PORT_W-1:0]             slot,
    output logic [lohs_pkg::FP_PORT_W-1:0]               found_footprint,
    output logic [lohs_pkg::FILL_PORT_W-1:0]             fill_count
);
    import lohs_pkg::*;

    lohs_state_t               state_reg;
    lohs_state_t               state_next;

    lohs_cmd_t                 cmd_reg;
    logic [KEY_W-1:0]          okey_reg;
    logic [KEY_W-1:0]          akey_reg;
    logic [FOOTPRINT_BITS-1:0] fp_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;

    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [SLOT_PORT_W-1:0]    slot_reg;
    logic [FP_PORT_W-1:0]      fp_out_reg;
    logic [FILL_PORT_W-1:0]    fill_reg;

    logic                      accept;
    logic                      fire;
    logic                      full;
    logic [SLOT_W-1:0]         victim;

    logic [ENTRIES-1:0]        lane_match;
    logic                      look_hit;
    logic [SLOT_W-1:0]         look_pos;
    logic [ENTRIES-1:0]        slot_match;
    logic                      touch_hit;
    logic [SLOT_W-1:0]         touch_slot;
    logic [SLOT_W-1:0]         touch_pos;

    logic                      res_hit;
    logic [SLOT_W-1:0]         res_slot;
    logic [FOOTPRINT_BITS-1:0] res_fp;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        fire     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_RESOLVE:
            begin
                fire = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            okey_reg <= offset_key;
            akey_reg <= address_key;
            fp_reg   <= entry_footprint[FOOTPRINT_BITS-1:0];
        end
    end

    // Resolve matches over the valid positions
    always_comb
    begin
        for (int c = 0; c < ENTRIES; c++)
        begin
            lane_match[c] = cell_match[c] && (COUNT_W'(c) < count_reg);
        end

        // Most recent match: lowest position
        look_hit = |lane_match;
        look_pos = '0;
        for (int c = ENTRIES - 1; c >= 0; c--)
        begin
            if (lane_match[c])
            begin
                look_pos = SLOT_W'(c);
            end
        end

        // Matches regrouped by slot number
        for (int s = 0; s < ENTRIES; s++)
        begin
            slot_match[s] = 1'b0;
            for (int c = 0; c < ENTRIES; c++)
            begin
                if (lane_match[c] && (cell_slot[c] == SLOT_W'(s)))
                begin
                    slot_match[s] = 1'b1;
                end
            end
        end

        // Lowest-numbered matching slot, then the position that holds it
        touch_hit  = |slot_match;
        touch_slot = '0;
        for (int s = ENTRIES - 1; s >= 0; s--)
        begin
            if (slot_match[s])
            begin
                touch_slot = SLOT_W'(s);
            end
        end
        touch_pos = '0;
        for (int c = 0; c < ENTRIES; c++)
        begin
            if (lane_match[c] && (cell_slot[c] == touch_slot))
            begin
                touch_pos = SLOT_W'(c);
            end
        end
    end

    // Pick the slot an insert writes
    assign full   = (count_reg == COUNT_W'(ENTRIES));
    assign victim = full ? cell_slot[ENTRIES-1] : SLOT_W'(count_reg);

    // Form the result and the fill count after this request
    always_comb
    begin
        res_hit    = 1'b0;
        res_slot   = '0;
        res_fp     = '0;
        count_next = count_reg;
        unique case (cmd_reg)
            CMD_LOOKUP_OFFSET, CMD_LOOKUP_ADDR:
            begin
                res_hit = look_hit;
                if (look_hit)
                begin
                    res_slot = cell_slot[look_pos];
                    res_fp   = cell_footprint[look_pos];
                end
            end
            CMD_INSERT:
            begin
                res_slot = victim;
                if (!full)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            CMD_TOUCH:
            begin
                res_hit = touch_hit;
                if (touch_hit)
                begin
                    res_slot = touch_slot;
                    res_fp   = cell_footprint[touch_pos];
                end
            end
            default:
            begin
                res_hit = 1'b0;
            end
        endcase
    end

    // Drive the head of the chain: new entry on insert, promoted entry on touch
    always_comb
    begin
        if (cmd_reg == CMD_INSERT)
        begin
            head_offset_key  = okey_reg;
            head_address_key = akey_reg;
            head_footprint   = fp_reg;
            head_slot        = victim;
        end
        else
        begin
            head_offset_key  = cell_offset_key[touch_pos];
            head_address_key = cell_address_key[touch_pos];
            head_footprint   = cell_footprint[touch_pos];
            head_slot        = cell_slot[touch_pos];
        end
    end

    // Advance the chain: the whole row on insert, up to the promoted position on touch
    always_comb
    begin
        for (int c = 0; c < ENTRIES; c++)
        begin
            cell_ctl[c].cmp_en  = accept;
            cell_ctl[c].by_addr = (cmd != CMD_LOOKUP_OFFSET);
            cell_ctl[c].shift   = fire &&
                ((cmd_reg == CMD_INSERT) ||
                 ((cmd_reg == CMD_TOUCH) && touch_hit && (SLOT_W'(c) <= touch_pos)));
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hit_reg    <= res_hit;
            slot_reg   <= SLOT_PORT_W'(res_slot);
            fp_out_reg <= FP_PORT_W'(res_fp);
            fill_reg   <= FILL_PORT_W'(count_next);
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign slot            = slot_reg;
    assign found_footprint = fp_out_reg;
    assign fill_count      = fill_reg;

endmodule

@@ tb/sv/tb_lru_ordered_history_set.sv @@
// Self-checking testbench for the LRU ordered history set.
`timescale 1ns / 1ps

module tb_lru_ordered_history_set;

    import lohs_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int FP_BITS      = 64;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int KEY_POOL     = 24;
    localparam int MAX_PRINTED  = 100;
    localparam logic [63:0] FP_MASK = (FP_BITS >= 64) ? '1 : ((64'd1 << FP_BITS) - 64'd1);

    typedef struct packed {
        lohs_cmd_t   cmd;
        logic [63:0] offset_key;
        logic [63:0] address_key;
        logic [63:0] footprint;
    } table_req_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic [63:0] footprint;
        logic [4:0]  fill;
    } table_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    lohs_cmd_t   cmd = CMD_LOOKUP_OFFSET;
    logic [63:0] offset_key = '0;
    logic [63:0] address_key = '0;
    logic [63:0] entry_footprint = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        hit;
    logic [3:0]  slot;
    logic [63:0] found_footprint;
    logic [4:0]  fill_count;

    // Shadow copy of the table contents and recency list
    logic [63:0] shadow_okey [ENTRIES];
    logic [63:0] shadow_akey [ENTRIES];
    logic [63:0] shadow_fp [ENTRIES];
    int          shadow_recency [ENTRIES];
    int          shadow_fill = 0;

    table_req_t    pending_requests[$];
    table_result_t expected_results[$];
    logic [63:0]   offset_pool [KEY_POOL];
    logic [63:0]   address_pool [KEY_POOL];

    int n_pushed = 0;
    int n_sent = 0;
    int mismatches = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    lru_ordered_history_set #(
        .ENTRIES(ENTRIES),
        .FOOTPRINT_BITS(FP_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .offset_key(offset_key),
        .address_key(address_key),
        .entry_footprint(entry_footprint),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .slot(slot),
        .found_footprint(found_footprint),
        .fill_count(fill_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one request to the shadow table and return the result it produces
    function automatic table_result_t apply_request(table_req_t r);
        table_result_t res;
        int            found;
        int            victim;
        int            p;
        int            q;
        res = '0;
        found = -1;
        case (r.cmd)
            CMD_LOOKUP_OFFSET, CMD_LOOKUP_ADDR:
            begin
                // search from most recent, no promotion
                for (p = 0; p < shadow_fill && found < 0; p++)
                begin
                    if (r.cmd == CMD_LOOKUP_OFFSET) begin
                        if (shadow_okey[shadow_recency[p]] == r.offset_key)
                            found = shadow_recency[p];
                    end else begin
                        if (shadow_akey[shadow_recency[p]] == r.address_key)
                            found = shadow_recency[p];
                    end
                end
            end
            CMD_INSERT:
            begin
                // take the next free slot, or evict the least recent one
                if (shadow_fill < ENTRIES)
                begin
                    victim = shadow_fill;
                    shadow_fill++;
                end else begin
                    victim = shadow_recency[ENTRIES-1];
                end
                shadow_okey[victim] = r.offset_key;
                shadow_akey[victim] = r.address_key;
                shadow_fp[victim]   = r.footprint & FP_MASK;
                for (p = ENTRIES - 1; p > 0; p--)
                    shadow_recency[p] = shadow_recency[p-1];
                shadow_recency[0] = victim;
                res.slot = victim[3:0];
            end
            default:
            begin
                // touch: lowest matching slot number, then move it to the front
                for (p = 0; p < shadow_fill && found < 0; p++)
                    if (shadow_akey[p] == r.address_key)
                        found = p;
                if (found >= 0)
                begin
                    for (p = 0; p < shadow_fill; p++)
                    begin
                        if (shadow_recency[p] == found)
                        begin
                            for (q = p; q > 0; q--)
                                shadow_recency[q] = shadow_recency[q-1];
                            shadow_recency[0] = found;
                            break;
                        end
                    end
                end
            end
        endcase
        if (found >= 0)
        begin
            res.hit = 1'b1;
            res.slot = found[3:0];
            res.footprint = shadow_fp[found];
        end
        res.fill = shadow_fill[4:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_request(lohs_cmd_t c, logic [63:0] ok, logic [63:0] ak,
                                 logic [63:0] fp);
        table_req_t r;
        r.cmd = c;
        r.offset_key = ok;
        r.address_key = ak;
        r.footprint = fp;
        pending_requests.push_back(r);
        n_pushed++;
    endtask

    // Mostly reuse keys from a small pool so that lookups and touches hit
    function automatic logic [63:0] pick_key(bit by_addr);
        int idx;
        idx = $urandom_range(KEY_POOL - 1);
        if ($urandom_range(99) < 15)
            return {$urandom, $urandom};
        return by_addr ? address_pool[idx] : offset_pool[idx];
    endfunction

    task automatic queue_random(int n);
        int        pick;
        lohs_cmd_t c;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                c = CMD_INSERT;
            else if (pick < 55)
                c = CMD_LOOKUP_OFFSET;
            else if (pick < 80)
                c = CMD_LOOKUP_ADDR;
            else
                c = CMD_TOUCH;
            queue_request(c, pick_key(1'b0), pick_key(1'b1), {$urandom, $urandom});
        end
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        queue_random(n);
        wait (n_sent == n_pushed);
    endtask

    // Driver: present the next request once the current one is taken
    always @(posedge clk)
    begin
        table_req_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                r.cmd = cmd;
                r.offset_key = offset_key;
                r.address_key = address_key;
                r.footprint = entry_footprint;
                expected_results.push_back(apply_request(r));
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    r = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    cmd <= r.cmd;
                    offset_key <= r.offset_key;
                    address_key <= r.address_key;
                    entry_footprint <= r.footprint;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: long hold-off on demand, otherwise random
    always @(posedge clk)
    begin
        if (holds_served != holds_asked)
        begin
            holds_served <= holds_asked;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Monitor: compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", {63'd0, hit}, 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", {63'd0, hit}, {63'd0, want.hit});
                if (slot !== want.slot)
                    report_mismatch("slot", {60'd0, slot}, {60'd0, want.slot});
                if (found_footprint !== want.footprint)
                    report_mismatch("found_footprint", found_footprint, want.footprint);
                if (fill_count !== want.fill)
                    report_mismatch("fill_count", {59'd0, fill_count}, {59'd0, want.fill});
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("lru_ordered_history_set verification failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_okey[i] = '0;
            shadow_akey[i] = '0;
            shadow_fp[i] = '0;
            shadow_recency[i] = 0;
        end
        for (int i = 0; i < KEY_POOL; i++)
        begin
            offset_pool[i] = {$urandom, $urandom};
            address_pool[i] = {$urandom, $urandom};
        end
        offset_pool[0] = '0;
        offset_pool[1] = '1;
        address_pool[0] = '1;
        address_pool[1] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: everything misses
        queue_request(CMD_LOOKUP_OFFSET, 64'd0, 64'd0, '1);
        queue_request(CMD_LOOKUP_ADDR, '1, '1, 64'd0);
        queue_request(CMD_TOUCH, '1, '1, '1);
        // Key and footprint extremes, with duplicate keys
        queue_request(CMD_INSERT, 64'd0, '1, '1);
        queue_request(CMD_INSERT, '1, 64'd0, 64'd0);
        queue_request(CMD_INSERT, 64'd0, '1, 64'h5555_5555_5555_5555);
        // Most recent duplicate wins a lookup, lowest slot wins a touch
        queue_request(CMD_LOOKUP_OFFSET, 64'd0, 64'd0, 64'd0);
        queue_request(CMD_TOUCH, 64'd0, '1, 64'd0);
        queue_request(CMD_LOOKUP_ADDR, 64'd0, '1, 64'd0);
        queue_request(CMD_LOOKUP_OFFSET, 64'h1234, 64'h1234, 64'd0);
        // Fill the table, then evict the least recent slot
        for (int i = 0; i < 14; i++)
            queue_request(CMD_INSERT, 64'h1000 + i, {32'hA5A5_0000, i}, {$urandom, $urandom});
        queue_request(CMD_LOOKUP_OFFSET, '1, 64'd0, 64'd0);
        wait (n_sent == n_pushed);

        // Hold results off for a long stretch while requests keep coming
        holds_asked++;
        run_phase(300, 0, 0);
        run_phase(300, 75, 0);
        run_phase(300, 0, 75);
        run_phase(300, 12, 12);

        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("lru_ordered_history_set verification clean");
        else
            $display("lru_ordered_history_set verification failed");
        $finish;
    end

endmodule

@@ lru_ordered_history_set.f @@
rtl/core/lohs_pkg.sv
rtl/core/lohs_cell.sv
rtl/core/lohs_ctrl.sv
rtl/core/lru_ordered_history_set.sv
tb/sv/tb_lru_ordered_history_set.sv
